// File: rtl/ptx_pkg.sv
package ptx_pkg;

    localparam int COORD_W   = 16;
    localparam int LEN_W     = 17;
    localparam int SQ_W      = 34;
    localparam int ACC_W     = 34;
    localparam int FRAC_BITS = 16;
    localparam int SPC_W     = 13;
    localparam int SPC_RESET = 800;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NO_STROKE = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      first_point;
        logic                      last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic                      status;
        logic                      cycle_end;
    } out_item_t;

endpackage

// File: rtl/polyline_to_xy_sample_cycle_core.sv
// Load beat: a last point adds a length pass, per segment two reads, squares and a square
// root wait, bounded by the serial root unit.
// Tick beat: a segment start adds reads plus three divides on the shared divider, a
// zero-sample segment reads and a single divide, a cycle end a reload of the first point.
// One beat at a time; a tick's result waits in the output register while the next beat is
// taken. Sync reset empties the stroke, spc = 800; vertex/length memories are not cleared.
module polyline_to_xy_sample_cycle_core #(
    parameter int MAX_VERTICES      = 64,
    parameter int MAX_CYCLE_SAMPLES = 4096
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ptx_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ptx_pkg::out_item_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ptx_pkg::SPC_W-1:0] cfg_data
);

    import ptx_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int TW = LEN_W + AW;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_C_START = 5'd1;
    localparam logic [4:0] ST_C_RD0   = 5'd2;
    localparam logic [4:0] ST_C_RD1   = 5'd3;
    localparam logic [4:0] ST_C_SUB   = 5'd4;
    localparam logic [4:0] ST_C_MUL   = 5'd5;
    localparam logic [4:0] ST_C_SQS   = 5'd6;
    localparam logic [4:0] ST_C_SQRT  = 5'd7;
    localparam logic [4:0] ST_C_FIN   = 5'd8;
    localparam logic [4:0] ST_C_HOLD  = 5'd9;
    localparam logic [4:0] ST_T_SEG   = 5'd10;
    localparam logic [4:0] ST_T_RD1   = 5'd11;
    localparam logic [4:0] ST_T_RD2   = 5'd12;
    localparam logic [4:0] ST_T_DIVN  = 5'd13;
    localparam logic [4:0] ST_T_DIVX  = 5'd14;
    localparam logic [4:0] ST_T_DIVY  = 5'd15;
    localparam logic [4:0] ST_T_RST   = 5'd16;
    localparam logic [4:0] ST_EMIT    = 5'd17;

    logic [4:0]                state_reg, state_next;
    logic [SPC_W-1:0]          spc_reg;
    logic [SPC_W-1:0]          s_eff;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [TW-1:0]             total_reg, total_next;
    logic                      ready_reg, ready_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [SPC_W-1:0]          left_reg, left_next;
    logic [SPC_W-1:0]          emit_reg, emit_next;
    logic [SPC_W-1:0]          n_reg, n_next;
    logic signed [ACC_W-1:0]   posx_reg, posx_next, posy_reg, posy_next;
    logic signed [ACC_W-1:0]   stepx_reg, stepx_next, stepy_reg, stepy_next;
    logic signed [COORD_W-1:0] heldx_reg, heldx_next, heldy_reg, heldy_next;
    logic signed [COORD_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [COORD_W:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]               sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [SQ_W-1:0]           prod_reg, prod_next;
    out_item_t                 res_reg, res_next;
    out_item_t                 mdata_reg, mdata_next;
    logic                      mvalid_reg, mvalid_next;

    // memory ports
    logic                      vtx_we;
    logic [AW-1:0]             vtx_waddr, vtx_raddr;
    logic [COORD_W-1:0]        vx_rdata, vy_rdata;
    logic                      len_we;
    logic [LEN_W-1:0]          len_rdata;

    // shared arithmetic units
    logic                      div_start, div_done;
    logic [SQ_W-1:0]           div_dividend, div_quotient;
    logic [TW-1:0]             div_divisor;
    logic                      sq_start, sq_done;
    logic [LEN_W-1:0]          sq_root;

    logic                      s_fire;
    logic [CW-1:0]             cnt_base;
    logic [CW-1:0]             idx_plus1;
    logic [AW-1:0]             idx_inc;
    logic signed [COORD_W:0]   rd_dx, rd_dy;
    logic [SQ_W-1:0]           absdx_sh, absdy_sh;
    logic [SQ_W-1:0]           magx, magy, tx, ty;
    logic signed [COORD_W-1:0] smp_x, smp_y;
    logic [SPC_W-1:0]          emit_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = mvalid_reg;
    assign m_data    = mdata_reg;

    // clamp of the sample count register
    always_comb begin
        if (spc_reg == '0) begin
            s_eff = SPC_W'(1);
        end else if (32'(spc_reg) > 32'(MAX_CYCLE_SAMPLES)) begin
            s_eff = SPC_W'(MAX_CYCLE_SAMPLES);
        end else begin
            s_eff = spc_reg;
        end
    end

    assign cnt_base  = s_data.first_point ? '0 : cnt_reg;
    assign vtx_we    = s_fire && (s_data.action == ACT_LOAD) && (cnt_base < CW'(MAX_VERTICES));
    assign vtx_waddr = cnt_base[AW-1:0];
    assign idx_plus1 = CW'(idx_reg) + 1'b1;
    assign idx_inc   = idx_reg + 1'b1;

    assign rd_dx = {vx_rdata[COORD_W-1], vx_rdata} - {x0_reg[COORD_W-1], x0_reg};
    assign rd_dy = {vy_rdata[COORD_W-1], vy_rdata} - {y0_reg[COORD_W-1], y0_reg};

    // |d| * 2^16 as divide operands
    assign absdx_sh = SQ_W'(dx_reg[COORD_W] ? -dx_reg : dx_reg) << FRAC_BITS;
    assign absdy_sh = SQ_W'(dy_reg[COORD_W] ? -dy_reg : dy_reg) << FRAC_BITS;

    // truncate toward zero
    assign magx  = posx_reg[ACC_W-1] ? SQ_W'(-posx_reg) : SQ_W'(posx_reg);
    assign magy  = posy_reg[ACC_W-1] ? SQ_W'(-posy_reg) : SQ_W'(posy_reg);
    assign tx    = magx >> FRAC_BITS;
    assign ty    = magy >> FRAC_BITS;
    assign smp_x = posx_reg[ACC_W-1] ? COORD_W'(-tx) : tx[COORD_W-1:0];
    assign smp_y = posy_reg[ACC_W-1] ? COORD_W'(-ty) : ty[COORD_W-1:0];

    assign emit_inc = emit_reg + 1'b1;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        ready_next   = ready_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        emit_next    = emit_reg;
        n_next       = n_reg;
        posx_next    = posx_reg;
        posy_next    = posy_reg;
        stepx_next   = stepx_reg;
        stepy_next   = stepy_reg;
        heldx_next   = heldx_reg;
        heldy_next   = heldy_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        mdata_next   = mdata_reg;
        mvalid_next  = mvalid_reg;
        vtx_raddr    = idx_reg;
        len_we       = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = total_reg;
        sq_start     = 1'b0;

        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.action == ACT_LOAD) begin
                        ready_next = 1'b0;
                        cnt_next   = vtx_we ? cnt_base + 1'b1 : cnt_base;
                        if (s_data.last_point) begin
                            state_next = ST_C_START;
                        end
                    end else if (!ready_reg) begin
                        res_next   = '{sample_x: '0, sample_y: '0,
                                       status: STATUS_NO_STROKE, cycle_end: 1'b0};
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_T_SEG;
                    end
                end
            end

            // ---- length pass over all stored segments ----
            ST_C_START: begin
                total_next = '0;
                idx_next   = '0;
                if (cnt_reg < CW'(2)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_C_RD0;
                end
            end
            ST_C_RD0: begin
                state_next = ST_C_RD1;
            end
            ST_C_RD1: begin
                x0_next    = vx_rdata;
                y0_next    = vy_rdata;
                vtx_raddr  = idx_inc;
                state_next = ST_C_SUB;
            end
            ST_C_SUB: begin
                dx_next    = rd_dx;
                dy_next    = rd_dy;
                state_next = ST_C_MUL;
            end
            ST_C_MUL: begin
                sqx_next   = 32'(dx_reg) * 32'(dx_reg);
                sqy_next   = 32'(dy_reg) * 32'(dy_reg);
                state_next = ST_C_SQS;
            end
            ST_C_SQS: begin
                sq_start   = 1'b1;
                state_next = ST_C_SQRT;
            end
            ST_C_SQRT: begin
                if (sq_done) begin
                    len_we     = 1'b1;
                    total_next = total_reg + TW'(sq_root);
                    idx_next   = idx_inc;
                    vtx_raddr  = idx_inc;
                    if (CW'(idx_inc) + 1'b1 < cnt_reg) begin
                        state_next = ST_C_RD1;
                    end else begin
                        state_next = ST_C_FIN;
                    end
                end
            end
            ST_C_FIN: begin
                idx_next   = '0;
                left_next  = '0;
                emit_next  = '0;
                posx_next  = '0;
                posy_next  = '0;
                stepx_next = '0;
                stepy_next = '0;
                vtx_raddr  = '0;
                state_next = (total_reg == '0) ? ST_IDLE : ST_C_HOLD;
            end
            ST_C_HOLD: begin
                heldx_next = vx_rdata;
                heldy_next = vy_rdata;
                ready_next = 1'b1;
                state_next = ST_IDLE;
            end

            // ---- playback tick ----
            ST_T_SEG: begin
                if (left_reg == '0 && idx_plus1 < cnt_reg) begin
                    state_next = ST_T_RD1;
                end else begin
                    if (left_reg != '0) begin
                        heldx_next = smp_x;
                        heldy_next = smp_y;
                        posx_next  = posx_reg + stepx_reg;
                        posy_next  = posy_reg + stepy_reg;
                        left_next  = left_reg - 1'b1;
                        if (left_reg == SPC_W'(1)) begin
                            idx_next = idx_inc;
                        end
                    end
                    res_next = '{sample_x: (left_reg != '0) ? smp_x : heldx_reg,
                                 sample_y: (left_reg != '0) ? smp_y : heldy_reg,
                                 status: STATUS_OK, cycle_end: (emit_inc >= s_eff)};
                    emit_next = emit_inc;
                    if (emit_inc >= s_eff) begin
                        // cycle wraps: rewind and reload the first point
                        idx_next   = '0;
                        left_next  = '0;
                        emit_next  = '0;
                        posx_next  = '0;
                        posy_next  = '0;
                        stepx_next = '0;
                        stepy_next = '0;
                        vtx_raddr  = '0;
                        state_next = ST_T_RST;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_T_RD1: begin
                x0_next    = vx_rdata;
                y0_next    = vy_rdata;
                prod_next  = SQ_W'(len_rdata) * SQ_W'(s_eff);
                vtx_raddr  = idx_inc;
                state_next = ST_T_RD2;
            end
            ST_T_RD2: begin
                dx_next    = rd_dx;
                dy_next    = rd_dy;
                div_start  = 1'b1;
                state_next = ST_T_DIVN;
            end
            ST_T_DIVN: begin
                if (div_done) begin
                    n_next = div_quotient[SPC_W-1:0];
                    if (div_quotient[SPC_W-1:0] != '0) begin
                        div_start    = 1'b1;
                        div_dividend = absdx_sh;
                        div_divisor  = TW'(div_quotient[SPC_W-1:0]);
                        state_next   = ST_T_DIVX;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_T_SEG;
                    end
                end
            end
            ST_T_DIVX: begin
                div_dividend = absdy_sh;
                div_divisor  = TW'(n_reg);
                if (div_done) begin
                    stepx_next = dx_reg[COORD_W] ? -div_quotient : div_quotient;
                    div_start  = 1'b1;
                    state_next = ST_T_DIVY;
                end
            end
            ST_T_DIVY: begin
                if (div_done) begin
                    stepy_next = dy_reg[COORD_W] ? -div_quotient : div_quotient;
                    left_next  = n_reg;
                    posx_next  = ACC_W'(x0_reg) <<< FRAC_BITS;
                    posy_next  = ACC_W'(y0_reg) <<< FRAC_BITS;
                    state_next = ST_T_SEG;
                end
            end
            ST_T_RST: begin
                heldx_next = vx_rdata;
                heldy_next = vy_rdata;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!mvalid_reg || m_ready) begin
                    mdata_next  = res_reg;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            spc_reg    <= SPC_W'(SPC_RESET);
            cnt_reg    <= '0;
            total_reg  <= '0;
            ready_reg  <= 1'b0;
            idx_reg    <= '0;
            left_reg   <= '0;
            emit_reg   <= '0;
            posx_reg   <= '0;
            posy_reg   <= '0;
            stepx_reg  <= '0;
            stepy_reg  <= '0;
            heldx_reg  <= '0;
            heldy_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (cfg_valid && cfg_ready) begin
                spc_reg <= cfg_data;
            end
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
            ready_reg  <= ready_next;
            idx_reg    <= idx_next;
            left_reg   <= left_next;
            emit_reg   <= emit_next;
            posx_reg   <= posx_next;
            posy_reg   <= posy_next;
            stepx_reg  <= stepx_next;
            stepy_reg  <= stepy_next;
            heldx_reg  <= heldx_next;
            heldy_reg  <= heldy_next;
            mvalid_reg <= mvalid_next;
        end
        n_reg     <= n_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        mdata_reg <= mdata_next;
    end

    ptx_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_vx_ram (
        .aclk  (aclk),
        .we    (vtx_we),
        .waddr (vtx_waddr),
        .wdata (s_data.point_x),
        .raddr (vtx_raddr),
        .rdata (vx_rdata)
    );

    ptx_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_vy_ram (
        .aclk  (aclk),
        .we    (vtx_we),
        .waddr (vtx_waddr),
        .wdata (s_data.point_y),
        .raddr (vtx_raddr),
        .rdata (vy_rdata)
    );

    ptx_ram #(.WIDTH(LEN_W), .DEPTH(MAX_VERTICES)) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (idx_reg),
        .wdata (sq_root),
        .raddr (idx_reg),
        .rdata (len_rdata)
    );

    ptx_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (SQ_W'(sqx_reg) + SQ_W'(sqy_reg)),
        .done     (sq_done),
        .root     (sq_root)
    );

    ptx_div #(.DW(SQ_W), .VW(TW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

endmodule

// File: rtl/ptx_ram.sv
module ptx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ptx_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ptx_div #(
    parameter int DW = 34,
    parameter int VW = 23
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(DW);
        end else if (cnt_reg != '0) begin
            rem_next = fits ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/ptx_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module ptx_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ptx_pkg::SQ_W-1:0]  radicand,
    output logic                      done,
    output logic [ptx_pkg::LEN_W-1:0] root
);

    import ptx_pkg::*;

    localparam int REM_W = LEN_W + 2;
    localparam int CNT_W = $clog2(LEN_W + 1);

    logic [SQ_W-1:0]  val_reg, val_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;

    assign r2    = {rem_reg[REM_W-3:0], val_reg[SQ_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};

    always_comb begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(LEN_W);
        end else if (cnt_reg != '0) begin
            val_next = {val_reg[SQ_W-3:0], 2'b00};
            if (r2 >= trial) begin
                rem_next  = r2 - trial;
                root_next = {root_reg[LEN_W-2:0], 1'b1};
            end else begin
                rem_next  = r2;
                root_next = {root_reg[LEN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
